// ===== rtl/sia_pkg.sv =====
// Package for the signed 64-bit ALU: operation codes, datapath commands and
// the command word that the sequencer hands to the datapath.
// No dependencies.
`default_nettype none

package sia_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned CntW  = 6;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_NEG = 3'd2,
    OP_ABS = 3'd3,
    OP_CMP = 3'd4,
    OP_MUL = 3'd5,
    OP_DIV = 3'd6,
    OP_REM = 3'd7
  } op_e;

  typedef enum logic [3:0] {
    CMD_HOLD,
    CMD_LOAD,
    CMD_ADD,
    CMD_SUB,
    CMD_NEG,
    CMD_ABS,
    CMD_MAG_A,
    CMD_MAG_B,
    CMD_MUL,
    CMD_DIV,
    CMD_QFIX,
    CMD_RFIX
  } cmd_e;

  typedef struct packed {
    cmd_e kind;
    logic negate;
  } dp_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/sia_if.sv =====
// Valid/ready channel interfaces for the operand word and the result word.
// No dependencies.
`default_nettype none

interface sia_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [63:0] operand_a;
  logic [63:0] operand_b;

  modport source (output valid, op, operand_a, operand_b, input ready);
  modport sink   (input valid, op, operand_a, operand_b, output ready);
endinterface

interface sia_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] result;
  logic        status;

  modport source (output valid, result, status, input ready);
  modport sink   (input valid, result, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/sia_datapath.sv =====
// Shared 65-bit adder/subtractor with its operand and accumulator registers.
// Performs one add, subtract, shift-add or restoring-division step per cycle.
// Depends on sia_pkg.
`default_nettype none

module sia_datapath (
  input  wire logic              clk_i,
  input  wire sia_pkg::dp_cmd_t  cmd_i,
  input  wire logic [63:0]       a_i,
  input  wire logic [63:0]       b_i,
  output logic      [64:0]       acc_o
);
  import sia_pkg::*;

  logic [63:0] x_q, x_d;
  logic [63:0] y_q, y_d;
  logic [64:0] acc_q, acc_d;
  logic [64:0] add_x, add_y, sum;
  logic        add_sub;

  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    case (cmd_i.kind)
      CMD_ADD: begin
        add_x = {x_q[63], x_q};
        add_y = {y_q[63], y_q};
      end
      CMD_SUB: begin
        add_x   = {x_q[63], x_q};
        add_y   = {y_q[63], y_q};
        add_sub = 1'b1;
      end
      CMD_NEG: begin
        add_y   = {x_q[63], x_q};
        add_sub = 1'b1;
      end
      CMD_ABS, CMD_MAG_A: begin
        add_y   = {x_q[63], x_q};
        add_sub = x_q[63];
      end
      CMD_MAG_B: begin
        add_y   = {y_q[63], y_q};
        add_sub = y_q[63];
      end
      CMD_MUL: begin
        add_x = {1'b0, acc_q[63:0]};
        add_y = y_q[0] ? {1'b0, x_q} : '0;
      end
      CMD_DIV: begin
        // Shift the next dividend bit into the partial remainder and try the divisor.
        add_x   = {acc_q[63:0], x_q[63]};
        add_y   = {1'b0, y_q};
        add_sub = 1'b1;
      end
      CMD_QFIX: begin
        add_y   = {1'b0, x_q};
        add_sub = cmd_i.negate;
      end
      CMD_RFIX: begin
        add_y   = {1'b0, acc_q[63:0]};
        add_sub = cmd_i.negate;
      end
      default: begin
        add_x = '0;
      end
    endcase
  end

  assign sum = add_x + (add_sub ? ~add_y : add_y) + {64'd0, add_sub};

  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    acc_d = acc_q;
    case (cmd_i.kind)
      CMD_LOAD: begin
        x_d   = a_i;
        y_d   = b_i;
        acc_d = '0;
      end
      CMD_ADD, CMD_SUB, CMD_NEG, CMD_ABS, CMD_QFIX, CMD_RFIX: begin
        acc_d = sum;
      end
      CMD_MAG_A: begin
        x_d = sum[63:0];
      end
      CMD_MAG_B: begin
        y_d = sum[63:0];
      end
      CMD_MUL: begin
        acc_d = {1'b0, sum[63:0]};
        x_d   = {x_q[62:0], 1'b0};
        y_d   = {1'b0, y_q[63:1]};
      end
      CMD_DIV: begin
        // The quotient bits fill x from the bottom as the dividend leaves at the top.
        if (!sum[64]) begin
          acc_d = sum;
          x_d   = {x_q[62:0], 1'b1};
        end else begin
          acc_d = {acc_q[63:0], x_q[63]};
          x_d   = {x_q[62:0], 1'b0};
        end
      end
      default: begin
        acc_d = acc_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

// ===== rtl/signed_int64_alu.sv =====
// Signed 64-bit ALU: add, subtract, negate, absolute value, compare, multiply,
// divide and remainder on one shared 65-bit adder. One word is taken at a time:
// add, subtract, negate, absolute value and compare pass through S_RUN,
// multiply through S_MUL (one shift-add per multiplier bit), divide and
// remainder through S_MAG_A and S_MAG_B (magnitudes), S_DIV (one restoring step
// per dividend bit) and S_FIX (sign fix-up); a zero divisor goes to S_DONE with
// status 1 and a result of zero. The result sits in its own output register,
// so the next word is accepted while an earlier result still waits to be taken.
// Depends on sia_pkg, sia_if and sia_datapath.
`default_nettype none

module signed_int64_alu (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sia_req_if.sink   req_i,
  sia_rsp_if.source rsp_o
);
  import sia_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RUN   = 8'b0000_0010,
    S_MAG_A = 8'b0000_0100,
    S_MAG_B = 8'b0000_1000,
    S_MUL   = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_FIX   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  op_e             op_q;
  logic            a_neg_q, b_neg_q, dz_q;
  logic            out_valid_q, out_valid_d;
  logic [63:0]     out_res_q;
  logic            out_status_q;

  dp_cmd_t         cmd;
  logic [64:0]     acc;
  logic [63:0]     fin_res;
  logic            accept, load_out;
  op_e             in_op;

  assign in_op  = op_e'(req_i.op);
  assign accept = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);

  sia_datapath u_dp (
    .clk_i (clk_i),
    .cmd_i (cmd),
    .a_i   (req_i.operand_a),
    .b_i   (req_i.operand_b),
    .acc_o (acc)
  );

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd.kind   = CMD_HOLD;
    cmd.negate = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd.kind = CMD_LOAD;
          cnt_d    = '0;
          if ((in_op == OP_DIV || in_op == OP_REM) && req_i.operand_b == '0) begin
            state_d = S_DONE;
          end else if (in_op == OP_MUL) begin
            state_d = S_MUL;
          end else if (in_op == OP_DIV || in_op == OP_REM) begin
            state_d = S_MAG_A;
          end else begin
            state_d = S_RUN;
          end
        end
      end
      S_RUN: begin
        case (op_q)
          OP_ADD:         cmd.kind = CMD_ADD;
          OP_SUB, OP_CMP: cmd.kind = CMD_SUB;
          OP_NEG:         cmd.kind = CMD_NEG;
          OP_ABS:         cmd.kind = CMD_ABS;
          default:        cmd.kind = CMD_HOLD;
        endcase
        state_d = S_DONE;
      end
      S_MAG_A: begin
        cmd.kind = CMD_MAG_A;
        state_d  = S_MAG_B;
      end
      S_MAG_B: begin
        cmd.kind = CMD_MAG_B;
        state_d  = S_DIV;
      end
      S_MUL: begin
        cmd.kind = CMD_MUL;
        cnt_d    = cnt_q + 1'b1;
        if (&cnt_q) begin
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        cmd.kind = CMD_DIV;
        cnt_d    = cnt_q + 1'b1;
        if (&cnt_q) begin
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        // The quotient takes the sign of a xor b, the remainder the sign of a.
        if (op_q == OP_DIV) begin
          cmd.kind   = CMD_QFIX;
          cmd.negate = a_neg_q ^ b_neg_q;
        end else begin
          cmd.kind   = CMD_RFIX;
          cmd.negate = a_neg_q;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign load_out = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    if (dz_q) begin
      fin_res = '0;
    end else if (op_q == OP_CMP) begin
      if (acc[64]) begin
        fin_res = '1;
      end else if (acc == '0) begin
        fin_res = '0;
      end else begin
        fin_res = 64'd1;
      end
    end else begin
      fin_res = acc[63:0];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= in_op;
      a_neg_q <= req_i.operand_a[63];
      b_neg_q <= req_i.operand_b[63];
      dz_q    <= (in_op == OP_DIV || in_op == OP_REM) && req_i.operand_b == '0;
    end
    if (load_out) begin
      out_res_q    <= fin_res;
      out_status_q <= dz_q;
    end
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.result = out_res_q;
  assign rsp_o.status = out_status_q;

endmodule

`default_nettype wire

// ===== tb/sv/sia_alu_checker.sv =====
// Checker for the signed 64-bit ALU: watches the operand and result channels,
// predicts each result word and compares it field by field.
// Depends on sia_pkg and sia_if.
`timescale 1ns / 100ps

module sia_alu_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  sia_req_if                req_mon,
  sia_rsp_if                rsp_mon,
  output int unsigned       err_cnt_o,
  output int unsigned       pend_cnt_o
);
  import sia_pkg::*;

  typedef struct packed {
    op_e         op;
    logic [63:0] result;
    logic        status;
  } alu_word_t;

  alu_word_t pending_results[$];

  function automatic alu_word_t alu_result(op_e op, logic [63:0] a, logic [63:0] b);
    alu_word_t   w;
    logic [63:0] mag_a;
    logic [63:0] mag_b;
    logic [63:0] quo;
    logic [63:0] rem;
    w.op     = op;
    w.result = '0;
    w.status = 1'b0;
    mag_a    = a[63] ? -a : a;
    mag_b    = b[63] ? -b : b;
    case (op)
      OP_ADD: w.result = a + b;
      OP_SUB: w.result = a - b;
      OP_NEG: w.result = -a;
      OP_ABS: w.result = mag_a;
      OP_CMP: begin
        if ($signed(a) > $signed(b)) w.result = 64'd1;
        else if ($signed(a) < $signed(b)) w.result = '1;
        else w.result = '0;
      end
      OP_MUL: w.result = a * b;
      default: begin
        if (b == '0) begin
          w.status = 1'b1;
        end else begin
          // Both work on magnitudes; the quotient takes the sign of the product
          // and the remainder that of the dividend.
          quo = mag_a / mag_b;
          rem = mag_a % mag_b;
          if (op == OP_DIV) w.result = (a[63] ^ b[63]) ? -quo : quo;
          else w.result = a[63] ? -rem : rem;
        end
      end
    endcase
    return w;
  endfunction

  always @(posedge clk_i) begin
    alu_word_t exp_w;
    if (rst_ni) begin
      if (req_mon.valid && req_mon.ready) begin
        pending_results.push_back(alu_result(op_e'(req_mon.op), req_mon.operand_a,
                                             req_mon.operand_b));
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (pending_results.size() == 0) begin
          $error("result word with nothing outstanding: result %h status %b",
                 rsp_mon.result, rsp_mon.status);
          err_cnt_o = err_cnt_o + 1;
        end else begin
          exp_w = pending_results.pop_front();
          if (rsp_mon.result !== exp_w.result) begin
            $error("%s result: expected %h, got %h", exp_w.op.name(), exp_w.result,
                   rsp_mon.result);
            err_cnt_o = err_cnt_o + 1;
          end
          if (rsp_mon.status !== exp_w.status) begin
            $error("%s status: expected %b, got %b", exp_w.op.name(), exp_w.status,
                   rsp_mon.status);
            err_cnt_o = err_cnt_o + 1;
          end
        end
      end
      pend_cnt_o = pending_results.size();
    end
  end

endmodule

// ===== tb/sv/tb_signed_int64_alu.sv =====
// Top of the signed 64-bit ALU testbench: clock, reset, operand words and
// result back-pressure in several idling phases, and the verdict.
// Depends on sia_pkg, sia_if, signed_int64_alu and sia_alu_checker.
`timescale 1ns / 100ps

module tb_signed_int64_alu;
  import sia_pkg::*;

  localparam logic [63:0] MaxPos = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MinNeg = 64'h8000_0000_0000_0000;
  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned err_cnt;
  int unsigned pend_cnt;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  sia_req_if op_bus ();
  sia_rsp_if res_bus ();

  signed_int64_alu dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (op_bus),
    .rsp_o  (res_bus)
  );

  sia_alu_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_mon    (op_bus),
    .rsp_mon    (res_bus),
    .err_cnt_o  (err_cnt),
    .pend_cnt_o (pend_cnt)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #(8_000_000);
    $display("== FAIL ==");
    $finish;
  end

  // Result back-pressure, redrawn every cycle at the falling edge.
  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_bus.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_word(input op_e op, input logic [63:0] a, input logic [63:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      op_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    op_bus.valid     = 1'b1;
    op_bus.op        = op;
    op_bus.operand_a = a;
    op_bus.operand_b = b;
    do @(posedge clk_i); while (!op_bus.ready);
    @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    logic [31:0] w;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: v = '0;
          1: v = 64'd1;
          2: v = AllOnes;
          3: v = MaxPos;
          default: v = MinNeg;
        endcase
      end
      1, 2: begin
        v = 64'($urandom_range(200));
        v = v - 64'd100;
      end
      3: begin
        w = $urandom;
        v = {{32{w[31]}}, w};
      end
      4: begin
        v = 64'd1 << $urandom_range(63);
        if ($urandom_range(1) == 1) v = -v;
      end
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  task automatic run_random(input int unsigned count);
    op_e         op;
    logic [63:0] a;
    logic [63:0] b;
    repeat (count) begin
      op = op_e'($urandom_range(7));
      a  = rand_operand();
      b  = rand_operand();
      if ((op == OP_DIV || op == OP_REM) && $urandom_range(9) == 0) b = '0;
      send_word(op, a, b);
    end
  endtask

  initial begin
    op_bus.valid     = 1'b0;
    op_bus.op        = OP_ADD;
    op_bus.operand_a = '0;
    op_bus.operand_b = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Wrap-around, most negative operand, compare ordering and the divider's
    // corner cases, all back to back.
    send_word(OP_ADD, MaxPos, 64'd1);
    send_word(OP_ADD, AllOnes, 64'd1);
    send_word(OP_SUB, MinNeg, 64'd1);
    send_word(OP_SUB, '0, MinNeg);
    send_word(OP_NEG, MinNeg, AllOnes);
    send_word(OP_NEG, '0, MaxPos);
    send_word(OP_ABS, MinNeg, '0);
    send_word(OP_ABS, -64'd5, MaxPos);
    send_word(OP_CMP, MinNeg, MaxPos);
    send_word(OP_CMP, MaxPos, MinNeg);
    send_word(OP_CMP, AllOnes, AllOnes);
    send_word(OP_MUL, MinNeg, AllOnes);
    send_word(OP_MUL, MaxPos, MaxPos);
    send_word(OP_MUL, -64'd3, 64'd5);
    send_word(OP_DIV, MaxPos, '0);
    send_word(OP_REM, MinNeg, '0);
    send_word(OP_DIV, MinNeg, AllOnes);
    send_word(OP_REM, MinNeg, AllOnes);
    send_word(OP_DIV, -64'd7, 64'd2);
    send_word(OP_REM, -64'd7, 64'd2);
    send_word(OP_REM, 64'd7, -64'd2);
    send_word(OP_DIV, 64'd3, 64'd10);
    send_word(OP_REM, -64'd3, 64'd10);
    send_word(OP_REM, 64'd3, -64'd10);
    send_word(OP_DIV, MinNeg, MinNeg);

    // Let the pipeline drain completely before the random phases.
    op_bus.valid = 1'b0;
    wait (pend_cnt == 0);
    @(negedge clk_i);

    run_random(250);
    send_idle_pct = 62;
    run_random(300);
    send_idle_pct = 0;
    stall_pct     = 62;
    run_random(300);
    send_idle_pct = 10;
    stall_pct     = 10;
    run_random(250);
    send_idle_pct = 0;
    stall_pct     = 0;
    run_random(150);

    op_bus.valid = 1'b0;
    wait (pend_cnt == 0);
    repeat (80) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sia_pkg.sv
rtl/sia_if.sv
rtl/sia_datapath.sv
rtl/signed_int64_alu.sv
tb/sv/sia_alu_checker.sv
tb/sv/tb_signed_int64_alu.sv
